### hw/rtl/fnu_pkg.sv
// fnu_pkg: shared types and constants for the face normal unit.
// Depends on nothing.
`timescale 1ns / 1ps
package fnu_pkg;
    localparam int MAG_BITS  = 30;  // normalised magnitudes lie in [0, 2^30)
    localparam int SUM_BITS  = 62;  // sum of three squares
    localparam int ROOT_BITS = 31;  // floor(sqrt(sum))
    localparam int NUM_BITS  = 45;  // m * 2^14 + r/2
    localparam int Q_BITS    = 15;  // quotient, at most 16384

    // square root cell payload
    typedef struct packed {
        logic [SUM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } sqrt_st_t;

    // division cell payload, one per component
    typedef struct packed {
        logic [NUM_BITS-1:0] rem;
        logic [Q_BITS-1:0]   quo;
    } div_st_t;

    // side data riding along the cells
    typedef struct packed {
        logic [2:0]          neg;
        logic                degen;
        logic [MAG_BITS-1:0] m_x;
        logic [MAG_BITS-1:0] m_y;
        logic [MAG_BITS-1:0] m_z;
    } side_t;
endpackage

### hw/rtl/fnu_sqrt_cell.sv
// fnu_sqrt_cell: one restoring square-root step (one root bit) with a register.
// Depends on fnu_pkg.
`timescale 1ns / 1ps
module fnu_sqrt_cell #(
    parameter int BIT_POS = 30
) (
    input  logic             aclk,
    input  logic             en,
    input  fnu_pkg::sqrt_st_t st_in,
    input  fnu_pkg::side_t    side_in,
    output fnu_pkg::sqrt_st_t st_out,
    output fnu_pkg::side_t    side_out
);
    import fnu_pkg::*;

    logic [SUM_BITS+1:0] trial;
    logic [SUM_BITS+1:0] rem_w;
    sqrt_st_t st_next;

    // trial = (2*root + 2^b) * 2^b; root bits below b are zero
    always_comb begin
        trial = ({{(SUM_BITS+2-ROOT_BITS){1'b0}}, st_in.root} << (BIT_POS + 1))
              + ({{(SUM_BITS+1){1'b0}}, 1'b1} << (2 * BIT_POS));
        rem_w = {2'b00, st_in.rem};
        st_next = st_in;
        if (rem_w >= trial) begin
            st_next.rem  = SUM_BITS'(rem_w - trial);
            st_next.root = st_in.root | (ROOT_BITS'(1) << BIT_POS);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_out   <= st_next;
            side_out <= side_in;
        end
    end
endmodule

### hw/rtl/fnu_div_cell.sv
// fnu_div_cell: one restoring division step for three components sharing a divisor.
// Depends on fnu_pkg.
`timescale 1ns / 1ps
module fnu_div_cell #(
    parameter int BIT_POS = 14
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [fnu_pkg::ROOT_BITS-1:0] div_in,
    input  fnu_pkg::div_st_t            st_in  [3],
    input  fnu_pkg::side_t              side_in,
    output logic [fnu_pkg::ROOT_BITS-1:0] div_out,
    output fnu_pkg::div_st_t            st_out [3],
    output fnu_pkg::side_t              side_out
);
    import fnu_pkg::*;

    logic [NUM_BITS+Q_BITS:0] dsh;
    div_st_t st_next [3];

    // subtract divisor * 2^b where it fits
    always_comb begin
        dsh = {{(NUM_BITS+Q_BITS+1-ROOT_BITS){1'b0}}, div_in} << BIT_POS;
        for (int i = 0; i < 3; i++) begin
            st_next[i] = st_in[i];
            if ({{(Q_BITS+1){1'b0}}, st_in[i].rem} >= dsh) begin
                st_next[i].rem = NUM_BITS'({{(Q_BITS+1){1'b0}}, st_in[i].rem} - dsh);
                st_next[i].quo = st_in[i].quo | (Q_BITS'(1) << BIT_POS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_out  <= div_in;
            st_out   <= st_next;
            side_out <= side_in;
        end
    end
endmodule

### hw/rtl/face_normal_unit.sv
// face_normal_unit: top level, edges, cross product, scaling, root and division cells.
// Depends on fnu_pkg, fnu_sqrt_cell, fnu_div_cell.
//
//  channel | dir | fields (tdata, low bit first)
//  s_axis  | in  | p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z (COORD_BITS each)
//  m_axis  | out | norm_x norm_y norm_z (16 each); tuser: degenerate
//
// One face per cycle unless the output stalls; registered in order: edges, products,
// cross product, squares, root then division cells (one bit each), output register.
// The whole pipeline advances when the output register is empty or being taken;
// s_axis_tready follows that. Reset clears the valid bits only.
`timescale 1ns / 1ps
module face_normal_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata, // p0_x..p2_z
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [47:0]             m_axis_tdata,  // norm_x, norm_y, norm_z
    output logic                    m_axis_tuser   // degenerate
);
    import fnu_pkg::*;

    localparam int EB = COORD_BITS + 1;        // raw edge width
    localparam int EW = (EB > 32) ? 32 : EB;   // shrunk edge width (below 2^31)
    localparam int PW = 2 * EW;                // product width
    localparam int CW = PW + 1;                // cross product width
    localparam int SH = (EB > 32) ? EB - 32 : 1; // shift search range
    localparam int SHB = $clog2(SH + 1) + 1;
    localparam int DEPTH = 4 + ROOT_BITS + Q_BITS;

    logic adv;
    logic [DEPTH:0] vld_reg;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-1:0], s_axis_tvalid};
        end
    end

    // stage 1: edges, magnitudes and shrink
    logic signed [COORD_BITS-1:0] p [9];
    logic signed [EB-1:0] e [6];
    logic [EB-1:0] em [6];
    logic [EB-1:0] eor [2];
    logic signed [EW-1:0] e_next [6];
    logic signed [EW-1:0] e_reg  [6];
    logic [SHB-1:0] esh [2];

    always_comb begin
        for (int i = 0; i < 9; i++) p[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
        for (int i = 0; i < 3; i++) begin
            e[i]   = EB'(p[3+i]) - EB'(p[i]);
            e[3+i] = EB'(p[6+i]) - EB'(p[i]);
        end
        for (int i = 0; i < 6; i++) em[i] = e[i][EB-1] ? EB'(-e[i]) : EB'(e[i]);
        for (int v = 0; v < 2; v++) begin
            eor[v] = em[3*v] | em[3*v+1] | em[3*v+2];
            esh[v] = '0;
            for (int k = 1; k <= SH; k++)
                if (EB > 32 && (eor[v] >> (k + 30)) != '0) esh[v] = SHB'(k);
        end
        for (int i = 0; i < 6; i++) begin
            e_next[i] = EW'(em[i] >> esh[i/3]);
            if (e[i][EB-1]) e_next[i] = -e_next[i];
        end
    end

    always_ff @(posedge aclk) if (adv) e_reg <= e_next;

    // stage 2: six products
    logic signed [PW-1:0] pr_reg [6];
    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_reg[0] <= e_reg[1] * e_reg[5];
            pr_reg[1] <= e_reg[2] * e_reg[4];
            pr_reg[2] <= e_reg[2] * e_reg[3];
            pr_reg[3] <= e_reg[0] * e_reg[5];
            pr_reg[4] <= e_reg[0] * e_reg[4];
            pr_reg[5] <= e_reg[1] * e_reg[3];
        end
    end

    // stage 3: cross product magnitudes and signs
    logic [CW-1:0] cm_reg [3];
    logic [2:0] neg_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [CW-1:0] c;
                c = CW'(pr_reg[2*i]) - CW'(pr_reg[2*i+1]);
                neg_reg[i] <= c[CW-1];
                cm_reg[i]  <= c[CW-1] ? CW'(-c) : CW'(c);
            end
        end
    end

    // stage 4: common normalising shift, then squares
    localparam int LB = $clog2(CW + 1);
    logic [CW-1:0] cor;
    logic [LB-1:0] lead;
    logic [MAG_BITS-1:0] mn [3];
    side_t side4;
    always_comb begin
        cor = cm_reg[0] | cm_reg[1] | cm_reg[2];
        lead = '0;
        for (int k = 0; k < CW; k++) if (cor[k]) lead = LB'(k);
        for (int i = 0; i < 3; i++) begin
            if (lead >= LB'(29))
                mn[i] = MAG_BITS'(cm_reg[i] >> (lead - LB'(29)));
            else
                mn[i] = MAG_BITS'(cm_reg[i] << (LB'(29) - lead));
        end
        side4.neg   = neg_reg;
        side4.degen = (cor == '0);
        side4.m_x   = mn[0];
        side4.m_y   = mn[1];
        side4.m_z   = mn[2];
    end

    side_t side5_reg;
    sqrt_st_t sq0;
    always_ff @(posedge aclk) begin
        if (adv) begin
            side5_reg <= side4;
            sq0.root  <= '0;
            sq0.rem   <= SUM_BITS'(mn[0] * mn[0]) + SUM_BITS'(mn[1] * mn[1])
                       + SUM_BITS'(mn[2] * mn[2]);
        end
    end

    // square root chain, one root bit per cell
    sqrt_st_t sq [ROOT_BITS+1];
    side_t    ss [ROOT_BITS+1];
    assign sq[0] = sq0;
    assign ss[0] = side5_reg;
    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
        fnu_sqrt_cell #(.BIT_POS(ROOT_BITS - 1 - g)) u_cell (
            .aclk(aclk), .en(adv),
            .st_in(sq[g]), .side_in(ss[g]),
            .st_out(sq[g+1]), .side_out(ss[g+1])
        );
    end

    // division chain, numerators m * 2^14 + r/2
    logic [ROOT_BITS-1:0] rt;
    logic [ROOT_BITS-1:0] dv [Q_BITS+1];
    div_st_t dst [Q_BITS+1][3];
    side_t   ds  [Q_BITS+1];
    always_comb begin
        rt = sq[ROOT_BITS].root;
        dst[0][0].rem = (NUM_BITS'(ss[ROOT_BITS].m_x) << 14) + NUM_BITS'(rt >> 1);
        dst[0][1].rem = (NUM_BITS'(ss[ROOT_BITS].m_y) << 14) + NUM_BITS'(rt >> 1);
        dst[0][2].rem = (NUM_BITS'(ss[ROOT_BITS].m_z) << 14) + NUM_BITS'(rt >> 1);
        for (int i = 0; i < 3; i++) dst[0][i].quo = '0;
        dv[0] = (rt == '0) ? ROOT_BITS'(1) : rt;
        ds[0] = ss[ROOT_BITS];
    end
    for (genvar g = 0; g < Q_BITS; g++) begin : g_div
        fnu_div_cell #(.BIT_POS(Q_BITS - 1 - g)) u_cell (
            .aclk(aclk), .en(adv), .div_in(dv[g]),
            .st_in(dst[g]), .side_in(ds[g]),
            .div_out(dv[g+1]), .st_out(dst[g+1]), .side_out(ds[g+1])
        );
    end

    // output register: signs and degenerate case
    logic [15:0] q_next [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_next[i] = {1'b0, dst[Q_BITS][i].quo};
            if (ds[Q_BITS].neg[i]) q_next[i] = -q_next[i];
            if (ds[Q_BITS].degen) q_next[i] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_axis_tdata <= {q_next[2], q_next[1], q_next[0]};
            m_axis_tuser <= ds[Q_BITS].degen;
        end
    end
    assign m_axis_tvalid = vld_reg[DEPTH];
endmodule
